### hdl/sdc_pkg.sv
// Shared types and constants for the sort and distinct-count unit.
package sdc_pkg;

	localparam int MAX_ITEMS_DEF  = 64;
	localparam int VALUE_BITS_DEF = 16;
	localparam int CNT_W          = 7;
	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

	typedef struct packed {
		logic [15:0] value;
		logic        end_of_set;
	} item_beat_t;

	typedef struct packed {
		logic [15:0]      distinct_value;
		logic [CNT_W-1:0] occurrences;
		logic             last_result;
		logic             overflow;
	} result_beat_t;

	typedef struct packed {
		logic shift;
	} cell_ctl_t;

endpackage

### hdl/sdc_cell.sv
// One cell of the insertion chain: holds a value and its count, passes a token right.
module sdc_cell #(
	parameter int VALUE_BITS = sdc_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sdc_pkg::cell_ctl_t            ctl,
	input  logic                          tin_vld,
	input  logic [VALUE_BITS-1:0]         tin_val,
	input  logic [sdc_pkg::CNT_W-1:0]     tin_cnt,
	input  logic                          right_vld,
	input  logic [VALUE_BITS-1:0]         right_val,
	input  logic [sdc_pkg::CNT_W-1:0]     right_cnt,
	output logic                          tout_vld,
	output logic [VALUE_BITS-1:0]         tout_val,
	output logic [sdc_pkg::CNT_W-1:0]     tout_cnt,
	output logic                          vld,
	output logic [VALUE_BITS-1:0]         val,
	output logic [sdc_pkg::CNT_W-1:0]     cnt
);
	import sdc_pkg::*;

	logic                  vld_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  tok_vld_q;
	logic [VALUE_BITS-1:0] tok_val_q;
	logic [CNT_W-1:0]      tok_cnt_q;

	logic                  vld_n;
	logic [VALUE_BITS-1:0] val_n;
	logic [CNT_W-1:0]      cnt_n;
	logic                  tok_vld_n;
	logic [VALUE_BITS-1:0] tok_val_n;
	logic [CNT_W-1:0]      tok_cnt_n;
	logic [CNT_W:0]        sum;
	logic [CNT_W-1:0]      sat;

	always_comb begin
		sum = {1'b0, cnt_q} + {1'b0, tin_cnt};
		sat = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
	end

	always_comb begin
		vld_n     = vld_q;
		val_n     = val_q;
		cnt_n     = cnt_q;
		tok_vld_n = 1'b0;
		tok_val_n = tok_val_q;
		tok_cnt_n = tok_cnt_q;
		priority if (ctl.shift) begin
			vld_n = right_vld;
			val_n = right_val;
			cnt_n = right_cnt;
		end else if (tin_vld && !vld_q) begin
			vld_n = 1'b1;
			val_n = tin_val;
			cnt_n = tin_cnt;
		end else if (tin_vld && tin_val == val_q) begin
			cnt_n = sat;
		end else if (tin_vld && tin_val < val_q) begin
			val_n     = tin_val;
			cnt_n     = tin_cnt;
			tok_vld_n = 1'b1;
			tok_val_n = val_q;
			tok_cnt_n = cnt_q;
		end else if (tin_vld) begin
			tok_vld_n = 1'b1;
			tok_val_n = tin_val;
			tok_cnt_n = tin_cnt;
		end else begin
			tok_vld_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			vld_q     <= vld_n;
			tok_vld_q <= tok_vld_n;
		end
	end

	always_ff @(posedge clk) begin
		val_q     <= val_n;
		cnt_q     <= cnt_n;
		tok_val_q <= tok_val_n;
		tok_cnt_q <= tok_cnt_n;
	end

	assign tout_vld = tok_vld_q;
	assign tout_val = tok_val_q;
	assign tout_cnt = tok_cnt_q;
	assign vld      = vld_q;
	assign val      = val_q;
	assign cnt      = cnt_q;

`ifndef SYNTH
	a_no_token_on_shift: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |-> !tin_vld)
		else $error("token arrived while the chain shifts");
	a_token_from_full: assert property (@(posedge clk) disable iff (!arst_n)
		tok_vld_q |-> vld_q)
		else $error("token passed by an empty cell");
	a_token_larger: assert property (@(posedge clk) disable iff (!arst_n)
		tok_vld_q |-> tok_val_q > val_q)
		else $error("passed token not larger than kept value");
`endif

endmodule

### hdl/sort_distinct_count_unit.sv
// Top level: systolic counting insertion sorter with ordered result drain.
// Loading: one item per cycle while item_stall is low; each value travels one cell per cycle
// to its place. After the end-of-set beat: a flush until no token is in flight, then one
// result per cycle while result_stall is low, from the head of the chain through an output
// register. Reset clears the state, the element count and every cell valid bit; the chain
// is empty after it.
module sort_distinct_count_unit #(
	parameter int MAX_ITEMS  = sdc_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = sdc_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sdc_pkg::item_beat_t   item,
	input  logic                  item_valid,
	output logic                  item_stall,
	output sdc_pkg::result_beat_t result,
	output logic                  result_valid,
	input  logic                  result_stall
);
	import sdc_pkg::*;

	localparam int EL_W = $clog2(MAX_ITEMS + 1);
	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_FLUSH = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]      state_q;
	logic [EL_W-1:0] elements_q;
	logic            dropped_q;
	logic            out_valid_q;
	result_beat_t    result_q;

	logic            accept;
	logic            full;
	logic            take_out;
	logic            load_out;
	cell_ctl_t       ctl;

	logic [MAX_ITEMS-1:0]  cell_vld;
	logic [VALUE_BITS-1:0] cell_val [MAX_ITEMS];
	logic [CNT_W-1:0]      cell_cnt [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]  tok_vld;
	logic [VALUE_BITS-1:0] tok_val  [MAX_ITEMS];
	logic [CNT_W-1:0]      tok_cnt  [MAX_ITEMS];

	logic                  head_vld;
	logic [VALUE_BITS-1:0] head_val;

	assign item_stall = (state_q != ST_LOAD);
	assign accept     = item_valid && !item_stall;
	assign full       = (elements_q == EL_W'(MAX_ITEMS));
	assign take_out   = out_valid_q && !result_stall;
	assign load_out   = (state_q == ST_DRAIN) && (!out_valid_q || !result_stall);
	assign ctl.shift  = load_out;
	assign head_vld   = accept && !full;
	assign head_val   = VALUE_BITS'(item.value);

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic                  tin_vld;
		logic [VALUE_BITS-1:0] tin_val;
		logic [CNT_W-1:0]      tin_cnt;
		logic                  r_vld;
		logic [VALUE_BITS-1:0] r_val;
		logic [CNT_W-1:0]      r_cnt;

		if (i == 0) begin : g_head
			assign tin_vld = head_vld;
			assign tin_val = head_val;
			assign tin_cnt = CNT_W'(1);
		end else begin : g_mid
			assign tin_vld = tok_vld[i-1];
			assign tin_val = tok_val[i-1];
			assign tin_cnt = tok_cnt[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign r_vld = 1'b0;
			assign r_val = '0;
			assign r_cnt = '0;
		end else begin : g_inner
			assign r_vld = cell_vld[i+1];
			assign r_val = cell_val[i+1];
			assign r_cnt = cell_cnt[i+1];
		end

		sdc_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.tin_vld   (tin_vld),
			.tin_val   (tin_val),
			.tin_cnt   (tin_cnt),
			.right_vld (r_vld),
			.right_val (r_val),
			.right_cnt (r_cnt),
			.tout_vld  (tok_vld[i]),
			.tout_val  (tok_val[i]),
			.tout_cnt  (tok_cnt[i]),
			.vld       (cell_vld[i]),
			.val       (cell_val[i]),
			.cnt       (cell_cnt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			elements_q  <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (take_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							elements_q <= elements_q + EL_W'(1);
						end
						if (item.end_of_set) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!(|tok_vld)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load_out && !cell_vld[1]) begin
						state_q    <= ST_LOAD;
						elements_q <= '0;
						dropped_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.distinct_value <= 16'(cell_val[0]);
			result_q.occurrences    <= cell_cnt[0];
			result_q.last_result    <= !cell_vld[1];
			result_q.overflow       <= dropped_q;
		end
	end

	assign result       = result_q;
	assign result_valid = out_valid_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		elements_q <= EL_W'(MAX_ITEMS))
		else $error("element count beyond capacity");
	a_drain_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !(|tok_vld))
		else $error("drain with a token still in flight");
	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |-> full)
		else $error("overflow flagged before the store filled");
`endif

endmodule
